FILE: sv/cop_pkg.sv
// Shared codes and fixed widths for the circle outline point generator.
// No dependencies; used by cop_front, cop_back and the top level.
package cop_pkg;

  localparam int COLOUR_BITS = 24;
  localparam int OCT_BITS    = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic [OCT_BITS-1:0] OCT_LAST = 3'd7;

endpackage

FILE: sv/cop_fifo.sv
// Short register queue that separates the front and back of the generator.
// Holds packed step records; no package dependencies.
module cop_fifo #(
  parameter int WIDTH = 74,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue occupancy exceeds its depth");

endmodule

FILE: sv/cop_front.sv
// Front end: accepts start and step transactions and advances the midpoint
// state. Depends on cop_pkg; pushes one packed record per productive item.
module cop_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            action,
  input  logic [COORD_BITS-1:0]           center_x,
  input  logic [COORD_BITS-1:0]           center_y,
  input  logic [COORD_BITS-2:0]           radius,
  input  logic [cop_pkg::COLOUR_BITS-1:0] colour,
  output logic                            job_valid,
  input  logic                            job_ready,
  output logic [4*COORD_BITS+cop_pkg::COLOUR_BITS+1:0] job_data
);

  localparam int C = COORD_BITS;
  localparam int D = COORD_BITS + 4;

  logic [C-1:0]                   offset_x;
  logic signed [C:0]              offset_y;
  logic signed [D-1:0]            decision;
  logic [C-1:0]                   centre_col;
  logic [C-1:0]                   centre_row;
  logic [cop_pkg::COLOUR_BITS-1:0] draw_colour;
  logic                           running;

  logic [C-1:0]        x_next;
  logic signed [C:0]   y_next;
  logic signed [D-1:0] d_next;
  logic signed [D-1:0] diff_ext;
  logic signed [D-1:0] x_ext;
  logic                fin;
  logic                is_start;
  logic                accept;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;
  assign is_start = (action == cop_pkg::ACT_START);

  always_comb begin
    x_next   = offset_x + 1'b1;
    x_ext    = signed'(D'(x_next));
    if (is_start) begin
      x_next   = '0;
      y_next   = signed'((C + 1)'(radius));
      d_next   = signed'(D'(3)) - signed'(D'({radius, 1'b0}));
      diff_ext = '0;
    end else if (decision > 0) begin
      y_next   = offset_y - signed'((C + 1)'(1));
      diff_ext = x_ext - D'(y_next);
      d_next   = decision + (diff_ext <<< 2) + signed'(D'(10));
    end else begin
      y_next   = offset_y;
      diff_ext = '0;
      d_next   = decision + (x_ext <<< 2) + signed'(D'(6));
    end
    fin = !is_start && (y_next < signed'({1'b0, x_next}));
  end

  // A step while no circle is running is taken and dropped.
  assign job_valid = in_valid && (is_start || running);
  assign job_data  = is_start
    ? {center_x, center_y, x_next, y_next, colour, 1'b0}
    : {centre_col, centre_row, x_next, y_next, draw_colour, fin};

  always_ff @(posedge clk) begin
    if (accept && (is_start || running)) begin
      offset_x <= x_next;
      offset_y <= y_next;
      decision <= d_next;
    end
    if (accept && is_start) begin
      centre_col  <= center_x;
      centre_row  <= center_y;
      draw_colour <= colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        running <= 1'b1;
      end else if (running && fin) begin
        running <= 1'b0;
      end
    end
  end

  a_running_order: assert property (@(posedge clk) disable iff (rst)
    running && $past(running) |-> !(offset_y < signed'({1'b0, offset_x})))
    else $error("circle still running after y fell below x");

endmodule

FILE: sv/cop_back.sv
// Back end: expands each step record into eight mirrored points, one per cycle
// when not stalled, through a registered output stage. Depends on cop_pkg.
module cop_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         job_valid,
  output logic                                         job_ready,
  input  logic [4*COORD_BITS+cop_pkg::COLOUR_BITS+1:0] job_data,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic signed [COORD_BITS+1:0]                 pixel_x,
  output logic signed [COORD_BITS+1:0]                 pixel_y,
  output logic [cop_pkg::COLOUR_BITS-1:0]              point_colour,
  output logic [cop_pkg::OCT_BITS-1:0]                 octant,
  output logic                                         last
);

  localparam int C  = COORD_BITS;
  localparam int O  = COORD_BITS + 2;
  localparam int CB = cop_pkg::COLOUR_BITS;

  logic [C-1:0]            cx;
  logic [C-1:0]            cy;
  logic [C-1:0]            jx;
  logic signed [C:0]       jy;
  logic [CB-1:0]           jcol;
  logic                    jfin;
  logic                    busy;
  logic [cop_pkg::OCT_BITS-1:0] oct;

  logic                    load_ok;
  logic                    emit;
  logic signed [O-1:0]     x_ext;
  logic signed [O-1:0]     y_ext;
  logic signed [O-1:0]     col_off;
  logic signed [O-1:0]     row_off;
  logic signed [O-1:0]     col_val;
  logic signed [O-1:0]     row_val;

  assign load_ok   = !out_valid || out_ready;
  assign emit      = busy && load_ok;
  assign job_ready = !busy || (emit && (oct == cop_pkg::OCT_LAST));

  // Octant bit 2 swaps the offsets, bit 0 mirrors the column, bit 1 the row.
  always_comb begin
    x_ext   = signed'(O'(jx));
    y_ext   = O'(jy);
    col_off = oct[2] ? y_ext : x_ext;
    row_off = oct[2] ? x_ext : y_ext;
    col_val = oct[0] ? signed'(O'(cx)) - col_off : signed'(O'(cx)) + col_off;
    row_val = oct[1] ? signed'(O'(cy)) - row_off : signed'(O'(cy)) + row_off;
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      {cx, cy, jx, jy, jcol, jfin} <= job_data;
    end
    if (emit) begin
      pixel_x      <= col_val;
      pixel_y      <= row_val;
      point_colour <= jcol;
      octant       <= oct;
      last         <= jfin && (oct == cop_pkg::OCT_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      oct       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (job_valid && job_ready) begin
        busy <= 1'b1;
        oct  <= '0;
      end else if (emit) begin
        oct <= oct + 1'b1;
        if (oct == cop_pkg::OCT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> octant == cop_pkg::OCT_LAST)
    else $error("last flag on a point other than the final octant");

  a_busy_emits: assert property (@(posedge clk) disable iff (rst)
    busy && !out_valid |=> out_valid)
    else $error("busy back end failed to present a point");

  a_pop_boundary: assert property (@(posedge clk) disable iff (rst)
    busy && job_ready |-> oct == cop_pkg::OCT_LAST)
    else $error("new record taken in the middle of a point group");

endmodule

FILE: sv/circle_outline_point_generator.sv
// Midpoint circle outline generator. A start transaction (action 0) loads the
// centre, radius and colour and yields the eight mirrored points of (0, r); each
// step transaction (action 1) advances the midpoint state and yields the next
// eight points, with last set on the final point of the closing step. A step
// while no circle is running is accepted and yields nothing. Every productive
// item yields eight points at one point per cycle when the output is not
// stalled, a pace set by the single-point output port. The front end updates
// the state as it accepts an item and hands a record through a two-entry queue,
// so it takes new items while the back end is still emitting earlier points;
// each record passes the queue, the back end's job register and the output
// register. Coordinates are signed and are not clipped.
// Depends on cop_pkg, cop_front, cop_fifo and cop_back.
module circle_outline_point_generator #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            action,
  input  logic [COORD_BITS-1:0]           center_x,
  input  logic [COORD_BITS-1:0]           center_y,
  input  logic [COORD_BITS-2:0]           radius,
  input  logic [cop_pkg::COLOUR_BITS-1:0] colour,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [COORD_BITS+1:0]    pixel_x,
  output logic signed [COORD_BITS+1:0]    pixel_y,
  output logic [cop_pkg::COLOUR_BITS-1:0] point_colour,
  output logic [cop_pkg::OCT_BITS-1:0]    octant,
  output logic                            last
);

  localparam int JW = 4 * COORD_BITS + cop_pkg::COLOUR_BITS + 2;

  logic          push_valid;
  logic          push_ready;
  logic [JW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [JW-1:0] pop_data;

  cop_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .colour    (colour),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job_data  (push_data)
  );

  cop_fifo #(.WIDTH(JW), .DEPTH(cop_pkg::QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cop_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (pop_valid),
    .job_ready    (pop_ready),
    .job_data     (pop_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .point_colour (point_colour),
    .octant       (octant),
    .last         (last)
  );

endmodule

FILE: tb/tb_circle_outline_point_generator.sv
// Self-checking testbench for circle_outline_point_generator: it predicts the eight
// mirrored points of every start and productive step transaction and checks them in order.
// Depends on cop_pkg and the circle_outline_point_generator RTL.
module tb_circle_outline_point_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB    = 12;
  localparam int LIMIT = 400000;
  localparam int DRAIN = 24;

  typedef struct packed {
    logic signed [CB+1:0]             px;
    logic signed [CB+1:0]             py;
    logic [cop_pkg::COLOUR_BITS-1:0]  paint;
    logic [cop_pkg::OCT_BITS-1:0]     oct;
    logic                             fin;
  } point_t;

  // Tracks the midpoint state and holds the points still owed by the block.
  class circle_point_tracker;
    point_t due_points[$];
    int     x_off, y_off, dec, ccol, crow;
    logic [cop_pkg::COLOUR_BITS-1:0] paint;
    bit     running;
    int     mismatches;
    int     productive;

    function void plot_octants(bit closing);
      point_t p;
      int a, b;
      logic [cop_pkg::OCT_BITS-1:0] k;
      for (int i = 0; i < 8; i++) begin
        k = cop_pkg::OCT_BITS'(i);
        // The upper four points swap the roles of x and y.
        a = k[2] ? y_off : x_off;
        b = k[2] ? x_off : y_off;
        p.px    = (CB+2)'(ccol + (k[0] ? -a : a));
        p.py    = (CB+2)'(crow + (k[1] ? -b : b));
        p.paint = paint;
        p.oct   = k;
        p.fin   = closing && (k == cop_pkg::OCT_LAST);
        due_points.push_back(p);
      end
    endfunction

    function void note_item(logic act, logic [CB-1:0] cx, logic [CB-1:0] cy,
                            logic [CB-2:0] r, logic [cop_pkg::COLOUR_BITS-1:0] c);
      if (act == cop_pkg::ACT_START) begin
        ccol    = int'(cx);
        crow    = int'(cy);
        paint   = c;
        x_off   = 0;
        y_off   = int'(r);
        dec     = 3 - 2 * int'(r);
        running = 1'b1;
        productive++;
        plot_octants(1'b0);
      end else if (running) begin
        x_off++;
        if (dec > 0) begin
          y_off--;
          dec = dec + 4 * (x_off - y_off) + 10;
        end else begin
          dec = dec + 4 * x_off + 6;
        end
        if (y_off < x_off) running = 1'b0;
        productive++;
        plot_octants(!running);
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (due_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point: x=%0d y=%0d colour=%06h octant=%0d last=%0b",
                   got.px, got.py, got.paint, got.oct, got.fin);
        return;
      end
      want = due_points.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"point mismatch: expected x=%0d y=%0d colour=%06h octant=%0d last=%0b,",
                    " got x=%0d y=%0d colour=%06h octant=%0d last=%0b"},
                   want.px, want.py, want.paint, want.oct, want.fin,
                   got.px, got.py, got.paint, got.oct, got.fin);
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             action = cop_pkg::ACT_STEP;
  logic [CB-1:0]                    center_x = '0;
  logic [CB-1:0]                    center_y = '0;
  logic [CB-2:0]                    radius = '0;
  logic [cop_pkg::COLOUR_BITS-1:0]  colour = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [CB+1:0]             pixel_x;
  logic signed [CB+1:0]             pixel_y;
  logic [cop_pkg::COLOUR_BITS-1:0]  point_colour;
  logic [cop_pkg::OCT_BITS-1:0]     octant;
  logic                             last;

  circle_point_tracker tracker;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int idle_tab[4]    = '{0, 51, 0, 10};
  int stall_tab[4]   = '{0, 0, 51, 10};

  circle_outline_point_generator #(.COORD_BITS(CB)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius       (radius),
    .colour       (colour),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .point_colour (point_colour),
    .octant       (octant),
    .last         (last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Transactions are sampled at the edge, before any driven value changes.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        tracker.note_item(action, center_x, center_y, radius, colour);
      if (out_valid && out_ready)
        tracker.check_point('{pixel_x, pixel_y, point_colour, octant, last});
    end
  end

  task automatic send_item(input logic act, input logic [CB-1:0] cx,
                           input logic [CB-1:0] cy, input logic [CB-2:0] r,
                           input logic [cop_pkg::COLOUR_BITS-1:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    center_x <= cx;
    center_y <= cy;
    radius   <= r;
    colour   <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Payload of a step is ignored by the block, so it is randomised anyway.
  task automatic step_item();
    send_item(cop_pkg::ACT_STEP, CB'($urandom_range(0, 4095)),
              CB'($urandom_range(0, 4095)), (CB-1)'($urandom_range(0, 2047)),
              cop_pkg::COLOUR_BITS'($urandom_range(0, 24'hffffff)));
  endtask

  task automatic start_random(input int r);
    send_item(cop_pkg::ACT_START, CB'($urandom_range(0, 4095)),
              CB'($urandom_range(0, 4095)), (CB-1)'(r),
              cop_pkg::COLOUR_BITS'($urandom_range(0, 24'hffffff)));
  endtask

  task automatic finish_circle(input int extra);
    while (tracker.running) step_item();
    repeat (extra) step_item();
  endtask

  task automatic random_circle();
    int pick;
    int r;
    int cap;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      step_item();
      return;
    end
    if (pick < 80) r = $urandom_range(0, 24);
    else if (pick < 93) r = $urandom_range(25, 300);
    else r = $urandom_range(1024, 2047);
    start_random(r);
    if (r <= 24 && $urandom_range(0, 99) < 80) begin
      finish_circle($urandom_range(0, 2));
    end else begin
      // Broken sequence: a few steps, then the next start drops this circle.
      cap = $urandom_range(0, 12);
      for (int i = 0; i < cap && tracker.running; i++) step_item();
    end
  endtask

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("circle_outline_point_generator regression: fail");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // A step straight after reset finds no circle and must yield nothing.
    step_item();
    // Zero radius at the origin corner: eight copies of the centre, then one
    // closing step.
    send_item(cop_pkg::ACT_START, '0, '0, '0, '0);
    step_item();
    step_item();
    // Largest radius at the far corner, then a restart at the near corner
    // while that circle is still running.
    send_item(cop_pkg::ACT_START, '1, '1, '1, '1);
    repeat (3) step_item();
    send_item(cop_pkg::ACT_START, '0, '0, '1, 24'h5a5a5a);
    repeat (2) step_item();
    send_item(cop_pkg::ACT_START, CB'(2048), CB'(1000), (CB-1)'(1), 24'ha5a5a5);
    finish_circle(1);
    start_random(3);
    finish_circle(0);
    start_random(5);
    finish_circle(1);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      while (tracker.productive < 25 + 58 * (ph + 1)) random_circle();
    end
    in_valid <= 1'b0;
    // Let the final accepted transaction reach the tracker before draining.
    @(posedge clk);

    while (tracker.due_points.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.due_points.size() == 0)
      $display("circle_outline_point_generator regression: pass");
    else
      $display("circle_outline_point_generator regression: fail");
    $finish;
  end

endmodule
